[design/stk_pkg.sv]
package stk_pkg;

  localparam int unsigned MaxResults = 4;
  localparam int unsigned ResIdxW    = $clog2(MaxResults);
  localparam int unsigned ResCntW    = $clog2(MaxResults + 1);

  typedef logic [7:0] byte_t;

  localparam byte_t CH_NUL    = 8'h00;
  localparam byte_t CH_LF     = 8'h0a;
  localparam byte_t CH_SPACE  = 8'h20;
  localparam byte_t CH_DQUOTE = 8'h22;
  localparam byte_t CH_APOS   = 8'h27;
  localparam byte_t CH_LPAR   = 8'h28;
  localparam byte_t CH_RPAR   = 8'h29;
  localparam byte_t CH_SLASH  = 8'h2f;
  localparam byte_t CH_COLON  = 8'h3a;
  localparam byte_t CH_UP_A   = 8'h41;
  localparam byte_t CH_UP_Z   = 8'h5a;
  localparam byte_t CH_BSLASH = 8'h5c;
  localparam byte_t CH_LBRACE = 8'h7b;
  localparam byte_t CH_RBRACE = 8'h7d;
  localparam byte_t CASE_BIT  = 8'h20;

  typedef enum logic [2:0] {
    LEX_BETWEEN = 3'd0,
    LEX_SLASH   = 3'd1,
    LEX_COMMENT = 3'd2,
    LEX_QUOTE   = 3'd3,
    LEX_WORD    = 3'd4
  } lex_state_t;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_END  = 2'd1,
    KIND_EOT  = 2'd2
  } kind_t;

  typedef struct packed {
    byte_t ch;
    kind_t kind;
  } res_t;

  // results of one byte, in emit order from index 0
  typedef struct packed {
    logic [ResCntW-1:0]    count;
    res_t [MaxResults-1:0] res;
  } step_t;

  function automatic logic is_break(input byte_t c);
    return (c == CH_LBRACE) || (c == CH_RBRACE) || (c == CH_LPAR) ||
           (c == CH_RPAR) || (c == CH_APOS) || (c == CH_COLON);
  endfunction

  function automatic byte_t fold(input byte_t c, input logic keep_case);
    if (!keep_case && (c >= CH_UP_A) && (c <= CH_UP_Z)) begin
      return c | CASE_BIT;
    end
    return c;
  endfunction

endpackage

[design/stk_lexer.sv]
module stk_lexer
  import stk_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  step,
  input  byte_t c,
  input  logic  keep_case,
  output step_t result
);

  lex_state_t lex_state, lex_state_next;
  logic       escape_pending, escape_pending_next;

  logic [ResCntW-1:0] cnt;
  logic               run_word;
  logic               run_between;

  always_comb begin
    cnt                 = '0;
    result.res          = '0;
    lex_state_next      = lex_state;
    escape_pending_next = escape_pending;
    run_word            = 1'b0;
    run_between         = 1'b0;

    case (lex_state)
      LEX_SLASH: begin
        if (c == CH_SLASH) begin
          lex_state_next = LEX_COMMENT;
        end else begin
          result.res[cnt[ResIdxW-1:0]] = '{ch: CH_SLASH, kind: KIND_CHAR};
          cnt = cnt + 1'b1;
          lex_state_next = LEX_WORD;
          run_word = 1'b1;
        end
      end
      LEX_COMMENT: begin
        if (c == CH_NUL) begin
          result.res[cnt[ResIdxW-1:0]] = '{ch: CH_NUL, kind: KIND_EOT};
          cnt = cnt + 1'b1;
          lex_state_next = LEX_BETWEEN;
        end else if (c == CH_LF) begin
          lex_state_next = LEX_BETWEEN;
        end
      end
      LEX_QUOTE: begin
        if (!keep_case) begin
          // lowercase mode: no escapes, any held backslash is dropped
          escape_pending_next = 1'b0;
          if ((c == CH_DQUOTE) || (c == CH_NUL)) begin
            result.res[cnt[ResIdxW-1:0]] = '{ch: CH_NUL, kind: KIND_END};
            cnt = cnt + 1'b1;
            lex_state_next = LEX_BETWEEN;
            if (c == CH_NUL) begin
              result.res[cnt[ResIdxW-1:0]] = '{ch: CH_NUL, kind: KIND_EOT};
              cnt = cnt + 1'b1;
            end
          end else begin
            result.res[cnt[ResIdxW-1:0]] = '{ch: fold(c, keep_case), kind: KIND_CHAR};
            cnt = cnt + 1'b1;
          end
        end else if (((c == CH_DQUOTE) && !escape_pending) || (c == CH_NUL)) begin
          escape_pending_next = 1'b0;
          result.res[cnt[ResIdxW-1:0]] = '{ch: CH_NUL, kind: KIND_END};
          cnt = cnt + 1'b1;
          lex_state_next = LEX_BETWEEN;
          if (c == CH_NUL) begin
            result.res[cnt[ResIdxW-1:0]] = '{ch: CH_NUL, kind: KIND_EOT};
            cnt = cnt + 1'b1;
          end
        end else begin
          // held backslash not followed by a quote comes out literally
          if ((c != CH_DQUOTE) && escape_pending) begin
            result.res[cnt[ResIdxW-1:0]] = '{ch: CH_BSLASH, kind: KIND_CHAR};
            cnt = cnt + 1'b1;
          end
          escape_pending_next = (c == CH_BSLASH);
          if (c != CH_BSLASH) begin
            result.res[cnt[ResIdxW-1:0]] = '{ch: c, kind: KIND_CHAR};
            cnt = cnt + 1'b1;
          end
        end
      end
      LEX_WORD: begin
        run_word = 1'b1;
      end
      default: begin
        run_between = 1'b1;
      end
    endcase

    if (run_word) begin
      if ((c <= CH_SPACE) || is_break(c)) begin
        // ending byte is re-handled as a byte between tokens
        result.res[cnt[ResIdxW-1:0]] = '{ch: CH_NUL, kind: KIND_END};
        cnt = cnt + 1'b1;
        run_between = 1'b1;
      end else begin
        result.res[cnt[ResIdxW-1:0]] = '{ch: fold(c, keep_case), kind: KIND_CHAR};
        cnt = cnt + 1'b1;
        lex_state_next = LEX_WORD;
      end
    end

    if (run_between) begin
      lex_state_next = LEX_BETWEEN;
      if (c == CH_NUL) begin
        result.res[cnt[ResIdxW-1:0]] = '{ch: CH_NUL, kind: KIND_EOT};
        cnt = cnt + 1'b1;
      end else if (c <= CH_SPACE) begin
        lex_state_next = LEX_BETWEEN;
      end else if (c == CH_SLASH) begin
        lex_state_next = LEX_SLASH;
      end else if (c == CH_DQUOTE) begin
        escape_pending_next = 1'b0;
        lex_state_next = LEX_QUOTE;
      end else if (is_break(c)) begin
        result.res[cnt[ResIdxW-1:0]] = '{ch: c, kind: KIND_CHAR};
        cnt = cnt + 1'b1;
        result.res[cnt[ResIdxW-1:0]] = '{ch: CH_NUL, kind: KIND_END};
        cnt = cnt + 1'b1;
      end else begin
        result.res[cnt[ResIdxW-1:0]] = '{ch: fold(c, keep_case), kind: KIND_CHAR};
        cnt = cnt + 1'b1;
        lex_state_next = LEX_WORD;
      end
    end

    result.count = cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lex_state      <= LEX_BETWEEN;
      escape_pending <= 1'b0;
    end else if (step) begin
      lex_state      <= lex_state_next;
      escape_pending <= escape_pending_next;
    end
  end

endmodule

[design/stk_outq.sv]
module stk_outq
  import stk_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  load,
  input  step_t result,
  output logic  can_load,
  output logic  m_tvalid,
  input  logic  m_tready,
  output byte_t m_tdata,
  output kind_t m_tuser,
  output logic  m_tlast
);

  res_t               ent [MaxResults];
  logic               busy;
  logic [ResIdxW-1:0] rd_idx;
  logic [ResIdxW-1:0] last_idx;
  logic               at_last;
  logic               pop;

  assign at_last  = (rd_idx == last_idx);
  assign pop      = busy && m_tready;
  assign can_load = !busy || (pop && at_last);

  assign m_tvalid = busy;
  assign m_tdata  = ent[rd_idx].ch;
  assign m_tuser  = ent[rd_idx].kind;
  assign m_tlast  = at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      rd_idx <= '0;
    end else if (load) begin
      busy   <= (result.count != '0);
      rd_idx <= '0;
    end else if (pop) begin
      if (at_last) begin
        busy <= 1'b0;
      end
      rd_idx <= rd_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      last_idx <= ResIdxW'(result.count - 1'b1);
      for (int i = 0; i < MaxResults; i++) begin
        ent[i] <= result.res[i];
      end
    end
  end

endmodule

[design/script_token_lexer.sv]
// Channel   | Dir | Beat contents
// ----------+-----+------------------------------------------------------------
// s_axis    | in  | tdata[7:0] in_char (0 ends the text)
// m_axis    | out | tdata[7:0] out_char, tuser[1:0] kind, tlast = last of byte
// cfg       | in  | cfg_wdata[0] preserve_mode, written when cfg_we is high
//
// One input byte per cycle when not stalled; a byte that makes n results holds
// the input while the buffer drains, one beat per ready cycle (n is 0 to 4).
// Bytes pass the input register, then the lexer step into the result buffer.
// Sync active-high rst returns the lexer to between-tokens, mode 0, empty.
// A stalled m_tready backs up through the result buffer to s_tready.
module script_token_lexer
  import stk_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // s_tdata: [7:0] in_char
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,
  // m_tdata: [7:0] out_char
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,
  // m_tuser: [1:0] kind
  output logic [1:0] m_tuser,
  output logic       m_tlast,
  input  logic       cfg_we,
  input  logic       cfg_wdata
);

  // input register
  logic  in_valid;
  byte_t in_byte;

  // preserve_mode register
  logic  keep_case;

  logic  can_load;
  logic  step;
  step_t result;
  kind_t out_kind;

  // step when the buffer is empty or hands off its last beat this cycle
  assign step     = in_valid && can_load;
  // no beat is taken while reset is held
  assign s_tready = !rst && (!in_valid || step);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_case <= 1'b0;
    end else if (cfg_we) begin
      keep_case <= cfg_wdata;
    end
  end

  stk_lexer u_lexer (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .c         (in_byte),
    .keep_case (keep_case),
    .result    (result)
  );

  stk_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .load     (step),
    .result   (result),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (out_kind),
    .m_tlast  (m_tlast)
  );

  assign m_tuser = out_kind;

endmodule

[design/stk_checker.sv]
module stk_checker
  import stk_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [1:0] m_tuser,
  input logic       m_tlast
);

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("output beat changed while stalled");

  // markers carry a zero character
  a_marker_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != KIND_CHAR) |-> (m_tdata == CH_NUL))
    else $error("marker beat with nonzero character");

  // end of text is always the final beat of its byte
  a_eot_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_EOT) |-> m_tlast)
    else $error("end of text not last of its byte");

  // buffer empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind script_token_lexer stk_checker u_stk_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

[tb/script_token_lexer_tb.sv]
module script_token_lexer_tb;
  import stk_pkg::*;

  // generous cycle ceiling
  localparam int unsigned CycleLimit = 400000;
  // cycles allowed after the last result for bytes that make no result
  localparam int unsigned SettleCycles = 8;
  // length of the long receiver hold-off
  localparam int unsigned LongHold = 300;

  // one output beat as the lexer should produce it
  typedef struct packed {
    byte_t ch;
    kind_t kind;
    logic  last;
  } lex_beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [1:0] m_tuser;
  logic       m_tlast;
  logic       cfg_we = 1'b0;
  logic       cfg_wdata = 1'b0;

  script_token_lexer dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),   // [7:0] in_char
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),   // [7:0] out_char
    .m_tuser   (m_tuser),   // [1:0] kind
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Lexer predictor: own copy of mode and state, fed once per accepted byte.
  // ---------------------------------------------------------------------------
  logic       keep_case = 1'b0;   // mirror of preserve_mode
  lex_state_t lx_state = LEX_BETWEEN;
  logic       bs_held = 1'b0;     // backslash waiting inside quotes

  byte_t     script_bytes[$];     // bytes waiting to be offered
  lex_beat_t step_beats[$];       // results of the byte being lexed
  lex_beat_t lexed_beats[$];      // results still owed by the block

  int unsigned errors = 0;

  function automatic logic breaks_token(byte_t c);
    return c == CH_LBRACE || c == CH_RBRACE || c == CH_LPAR || c == CH_RPAR ||
           c == CH_APOS || c == CH_COLON;
  endfunction

  function automatic byte_t to_lower(byte_t c);
    if (!keep_case && c >= CH_UP_A && c <= CH_UP_Z) return c + 8'd32;
    return c;
  endfunction

  function automatic void put_beat(byte_t ch, kind_t k);
    lex_beat_t b;
    b.ch = ch;
    b.kind = k;
    b.last = 1'b0;
    if (step_beats.size() < MaxResults) step_beats.push_back(b);
  endfunction

  function automatic void lex_between(byte_t c);
    lx_state = LEX_BETWEEN;
    if (c == CH_NUL) begin
      put_beat(CH_NUL, KIND_EOT);
    end else if (c <= CH_SPACE) begin
      // whitespace and control bytes are dropped
    end else if (c == CH_SLASH) begin
      lx_state = LEX_SLASH;
    end else if (c == CH_DQUOTE) begin
      bs_held = 1'b0;
      lx_state = LEX_QUOTE;
    end else if (breaks_token(c)) begin
      put_beat(c, KIND_CHAR);
      put_beat(CH_NUL, KIND_END);
    end else begin
      put_beat(to_lower(c), KIND_CHAR);
      lx_state = LEX_WORD;
    end
  endfunction

  function automatic void lex_word(byte_t c);
    if (c <= CH_SPACE || breaks_token(c)) begin
      // the ending byte is relexed as a between-token byte
      put_beat(CH_NUL, KIND_END);
      lex_between(c);
    end else begin
      put_beat(to_lower(c), KIND_CHAR);
    end
  endfunction

  function automatic void tokenize_byte(byte_t c);
    step_beats.delete();
    case (lx_state)
      LEX_SLASH: begin
        if (c == CH_SLASH) begin
          lx_state = LEX_COMMENT;
        end else begin
          // lone slash opens a word
          put_beat(CH_SLASH, KIND_CHAR);
          lx_state = LEX_WORD;
          lex_word(c);
        end
      end
      LEX_COMMENT: begin
        if (c == CH_NUL) begin
          put_beat(CH_NUL, KIND_EOT);
          lx_state = LEX_BETWEEN;
        end else if (c == CH_LF) begin
          lx_state = LEX_BETWEEN;
        end
      end
      LEX_QUOTE: begin
        if (!keep_case) begin
          // mode 0: no escapes, a held backslash is simply forgotten
          bs_held = 1'b0;
          if (c == CH_DQUOTE || c == CH_NUL) begin
            put_beat(CH_NUL, KIND_END);
            lx_state = LEX_BETWEEN;
            if (c == CH_NUL) put_beat(CH_NUL, KIND_EOT);
          end else begin
            put_beat(to_lower(c), KIND_CHAR);
          end
        end else if ((c == CH_DQUOTE && !bs_held) || c == CH_NUL) begin
          bs_held = 1'b0;
          put_beat(CH_NUL, KIND_END);
          lx_state = LEX_BETWEEN;
          if (c == CH_NUL) put_beat(CH_NUL, KIND_EOT);
        end else begin
          // held backslash before anything but a quote comes out as itself
          if (c != CH_DQUOTE && bs_held) put_beat(CH_BSLASH, KIND_CHAR);
          bs_held = (c == CH_BSLASH);
          if (!bs_held) put_beat(c, KIND_CHAR);
        end
      end
      LEX_WORD: lex_word(c);
      default:  lex_between(c);
    endcase
    if (step_beats.size() != 0) step_beats[step_beats.size() - 1].last = 1'b1;
    foreach (step_beats[i]) lexed_beats.push_back(step_beats[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: offers queued bytes, idling at the current send rate.
  // A byte is lexed by the predictor on the edge where it is accepted.
  // ---------------------------------------------------------------------------
  int unsigned send_idle = 25;   // percent of cycles the sender holds back
  int unsigned recv_idle = 85;   // percent of cycles the receiver stalls

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'h00;
    end else begin
      if (s_tvalid && s_tready) tokenize_byte(s_tdata);
      // slot is free if nothing was offered or the offer was just taken
      if (!s_tvalid || s_tready) begin
        if (script_bytes.size() != 0 && $urandom_range(99) >= send_idle) begin
          s_tvalid <= 1'b1;
          s_tdata  <= script_bytes.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output monitor: checks each beat against the oldest owed result and
  // drives m_tready, including one long hold-off on request.
  // ---------------------------------------------------------------------------
  logic        hold_req = 1'b0;
  logic        hold_taken = 1'b0;
  int unsigned hold_left = 0;

  always @(posedge clk) begin
    lex_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (lexed_beats.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat ch=%h kind=%0d last=%b",
                 $time, m_tdata, m_tuser, m_tlast);
      end else begin
        want = lexed_beats.pop_front();
        if (m_tdata !== want.ch) begin
          errors++;
          $display("%0t: out_char expected %h actual %h", $time, want.ch, m_tdata);
        end
        if (m_tuser !== want.kind) begin
          errors++;
          $display("%0t: kind expected %0d actual %0d", $time, want.kind, m_tuser);
        end
        if (m_tlast !== want.last) begin
          errors++;
          $display("%0t: last expected %b actual %b", $time, want.last, m_tlast);
        end
      end
    end
    if (hold_req && !hold_taken) begin
      hold_left  = LongHold;
      hold_taken = 1'b1;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // cycle ceiling
  int unsigned cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) script_bytes.push_back(s[i]);
  endtask

  // wait until every byte is in and every result is out, then let bytes
  // that made no result clear the pipeline
  task automatic drain_all();
    do @(negedge clk);
    while (script_bytes.size() != 0 || s_tvalid || lexed_beats.size() != 0);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_mode(logic m);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we    <= 1'b0;
    keep_case = m;
    @(negedge clk);
  endtask

  function automatic byte_t word_char();
    byte_t c;
    case ($urandom_range(0, 4))
      0: c = byte_t'($urandom_range(8'h41, 8'h5a));          // upper case
      1: c = byte_t'($urandom_range(8'h61, 8'h7a));          // lower case
      2: c = byte_t'($urandom_range(8'h80, 8'hff));          // high bytes
      default: begin
        do c = byte_t'($urandom_range(8'h21, 8'h7f));
        while (breaks_token(c));
      end
    endcase
    return c;
  endfunction

  function automatic byte_t break_char();
    case ($urandom_range(0, 5))
      0: return CH_LBRACE;
      1: return CH_RBRACE;
      2: return CH_LPAR;
      3: return CH_RPAR;
      4: return CH_APOS;
      default: return CH_COLON;
    endcase
  endfunction

  // Mostly well-formed script: words, quoted strings with escapes,
  // comments, break characters, whitespace; some noise and broken pieces.
  task automatic gen_script(int unsigned n);
    byte_t q[$];
    int unsigned len;
    while (q.size() < n) begin
      case ($urandom_range(0, 11))
        0, 1, 2: begin
          len = $urandom_range(1, 6);
          repeat (len) q.push_back(word_char());
          case ($urandom_range(0, 6))
            0: q.push_back(8'h09);
            1: q.push_back(CH_LF);
            2: q.push_back(break_char());
            3: q.push_back(byte_t'($urandom_range(1, 32)));
            4: q.push_back(CH_NUL);          // word cut by end of text
            default: q.push_back(CH_SPACE);
          endcase
        end
        3, 4, 5: begin
          q.push_back(CH_DQUOTE);
          len = $urandom_range(0, 5);
          repeat (len) begin
            case ($urandom_range(0, 5))
              0: q.push_back(CH_BSLASH);
              1: begin
                q.push_back(CH_BSLASH);
                q.push_back(CH_DQUOTE);
              end
              2: q.push_back(CH_SPACE);
              default: q.push_back(word_char());
            endcase
          end
          // now and then the string is left open or cut by a zero
          case ($urandom_range(0, 9))
            0: ;
            1: q.push_back(CH_NUL);
            default: q.push_back(CH_DQUOTE);
          endcase
        end
        6: begin
          q.push_back(CH_SLASH);
          if ($urandom_range(0, 3) != 0) begin
            q.push_back(CH_SLASH);
            len = $urandom_range(0, 4);
            repeat (len) q.push_back(word_char());
            q.push_back(($urandom_range(0, 5) == 0) ? CH_NUL : CH_LF);
          end
        end
        7: q.push_back(break_char());
        8: q.push_back(byte_t'($urandom_range(0, 32)));
        9, 10: q.push_back(byte_t'($urandom_range(0, 255)));   // noise
        default: q.push_back(CH_SPACE);
      endcase
    end
    foreach (q[i]) script_bytes.push_back(q[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // mode 0 after reset. Word "Az" cut by a brace (five results), slash
    // then letter, high bytes, quote inside a word, comment cut by zero,
    // empty quoted string.
    push_text("Az{/Q");
    script_bytes.push_back(8'hff);
    script_bytes.push_back(8'h80);
    push_text("\" //");
    script_bytes.push_back(CH_NUL);
    push_text("\"\"");
    drain_all();

    // mode 1: kept case, escaped quote, backslash before a letter, double
    // backslash, word cut by zero, zero in quotes with a held backslash,
    // then a quote left open with a backslash held.
    write_mode(1'b1);
    push_text("\"A\\\"\\b\\\\\"\"W");
    script_bytes.push_back(CH_NUL);
    push_text("\"\\");
    script_bytes.push_back(CH_NUL);
    push_text("\"\\");
    drain_all();

    // back to mode 0 inside that string: the held backslash is dropped
    write_mode(1'b0);
    push_text("c\"");
    gen_script(30);
    drain_all();

    // swap idle rates; receiver holds off long while bytes keep coming
    write_mode(1'b1);
    send_idle = 85;
    recv_idle = 25;
    hold_req  = 1'b1;
    gen_script(35);
    drain_all();

    // no idling from here on
    write_mode(1'b0);
    send_idle = 0;
    recv_idle = 0;
    gen_script(25);
    drain_all();

    write_mode(1'b1);
    gen_script(25);
    drain_all();

    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
